>>> rtl/dwpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwpd_pkg
// Shared widths, register indexes and types for the dual wheel PD
// velocity unit.
// ----------------------------------------------------------------------------
package dwpd_pkg;

    localparam int VALUE_BITS    = 16;
    localparam int FRACTION_BITS = 8;
    localparam int GAIN_BITS     = 16;

    // derived arithmetic widths
    localparam int ERR_BITS   = VALUE_BITS + 1;
    localparam int DELTA_BITS = VALUE_BITS + 2;
    localparam int GS_BITS    = GAIN_BITS + 1;          // gain with zero sign bit
    localparam int PP_BITS    = GS_BITS + ERR_BITS;
    localparam int PD_BITS    = GS_BITS + DELTA_BITS;
    localparam int SUM_BITS   = PD_BITS + 1;
    localparam int CMD_BITS   = SUM_BITS - FRACTION_BITS;

    // configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = (GAIN_BITS > VALUE_BITS) ? GAIN_BITS : VALUE_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PROP_GAIN        = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DERIV_GAIN       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_LIMIT_HIGH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_LIMIT_LOW   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_LIMIT_HIGH = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_LIMIT_LOW  = 3'd5;

    localparam logic [GAIN_BITS-1:0]  PROP_GAIN_RST  = GAIN_BITS'(256);
    localparam logic [GAIN_BITS-1:0]  DERIV_GAIN_RST = '0;
    localparam logic [VALUE_BITS-1:0] LIMIT_HIGH_RST = VALUE_BITS'(25600);
    localparam logic [VALUE_BITS-1:0] LIMIT_LOW_RST  = '0;

    typedef struct packed {
        logic        [GAIN_BITS-1:0]  prop_gain;
        logic        [GAIN_BITS-1:0]  deriv_gain;
        logic signed [VALUE_BITS-1:0] left_limit_high;
        logic signed [VALUE_BITS-1:0] left_limit_low;
        logic signed [VALUE_BITS-1:0] right_limit_high;
        logic signed [VALUE_BITS-1:0] right_limit_low;
    } t_cfg;

    // per-wheel products held between the two halves of the pass
    typedef struct packed {
        logic signed [PP_BITS-1:0] prod_p;
        logic signed [PD_BITS-1:0] prod_d;
    } t_prod;

endpackage
`default_nettype wire

>>> rtl/dwpd_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwpd_cfg_regs
// Gain and limit registers behind the plain write port.
// ----------------------------------------------------------------------------
module dwpd_cfg_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wen,
    input  wire logic [dwpd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [dwpd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output dwpd_pkg::t_cfg                           o_cfg
);

    dwpd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain        <= dwpd_pkg::PROP_GAIN_RST;
            r_cfg.deriv_gain       <= dwpd_pkg::DERIV_GAIN_RST;
            r_cfg.left_limit_high  <= dwpd_pkg::LIMIT_HIGH_RST;
            r_cfg.left_limit_low   <= dwpd_pkg::LIMIT_LOW_RST;
            r_cfg.right_limit_high <= dwpd_pkg::LIMIT_HIGH_RST;
            r_cfg.right_limit_low  <= dwpd_pkg::LIMIT_LOW_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                dwpd_pkg::CFG_PROP_GAIN: begin
                    r_cfg.prop_gain <= i_cfg_data[dwpd_pkg::GAIN_BITS-1:0];
                end
                dwpd_pkg::CFG_DERIV_GAIN: begin
                    r_cfg.deriv_gain <= i_cfg_data[dwpd_pkg::GAIN_BITS-1:0];
                end
                dwpd_pkg::CFG_LEFT_LIMIT_HIGH: begin
                    r_cfg.left_limit_high <= i_cfg_data[dwpd_pkg::VALUE_BITS-1:0];
                end
                dwpd_pkg::CFG_LEFT_LIMIT_LOW: begin
                    r_cfg.left_limit_low <= i_cfg_data[dwpd_pkg::VALUE_BITS-1:0];
                end
                dwpd_pkg::CFG_RIGHT_LIMIT_HIGH: begin
                    r_cfg.right_limit_high <= i_cfg_data[dwpd_pkg::VALUE_BITS-1:0];
                end
                dwpd_pkg::CFG_RIGHT_LIMIT_LOW: begin
                    r_cfg.right_limit_low <= i_cfg_data[dwpd_pkg::VALUE_BITS-1:0];
                end
                default: begin
                    // unused indexes are ignored
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> rtl/dwpd_wheel_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwpd_wheel_front
// Error, error change and the two gain products for one wheel.
// ----------------------------------------------------------------------------
module dwpd_wheel_front (
    input  wire logic signed [dwpd_pkg::VALUE_BITS-1:0] i_target,
    input  wire logic signed [dwpd_pkg::VALUE_BITS-1:0] i_measured,
    input  wire logic signed [dwpd_pkg::ERR_BITS-1:0]   i_last_error,
    input  wire logic        [dwpd_pkg::GAIN_BITS-1:0]  i_prop_gain,
    input  wire logic        [dwpd_pkg::GAIN_BITS-1:0]  i_deriv_gain,
    output logic signed      [dwpd_pkg::ERR_BITS-1:0]   o_error,
    output dwpd_pkg::t_prod                              o_prod
);

    logic signed [dwpd_pkg::DELTA_BITS-1:0] delta;
    logic signed [dwpd_pkg::GS_BITS-1:0]    kp_s;
    logic signed [dwpd_pkg::GS_BITS-1:0]    kd_s;

    assign o_error = dwpd_pkg::ERR_BITS'(i_target) - dwpd_pkg::ERR_BITS'(i_measured);
    assign delta   = dwpd_pkg::DELTA_BITS'(o_error) - dwpd_pkg::DELTA_BITS'(i_last_error);

    // gains are unsigned: add a zero sign bit
    assign kp_s = signed'({1'b0, i_prop_gain});
    assign kd_s = signed'({1'b0, i_deriv_gain});

    assign o_prod.prod_p = dwpd_pkg::PP_BITS'(kp_s) * dwpd_pkg::PP_BITS'(o_error);
    assign o_prod.prod_d = dwpd_pkg::PD_BITS'(kd_s) * dwpd_pkg::PD_BITS'(delta);

endmodule
`default_nettype wire

>>> rtl/dwpd_wheel_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwpd_wheel_back
// Sum, floor shift and high-then-low clamp for one wheel.
// ----------------------------------------------------------------------------
module dwpd_wheel_back (
    input  wire dwpd_pkg::t_prod                         i_prod,
    input  wire logic signed [dwpd_pkg::VALUE_BITS-1:0] i_limit_high,
    input  wire logic signed [dwpd_pkg::VALUE_BITS-1:0] i_limit_low,
    output logic signed      [dwpd_pkg::VALUE_BITS-1:0] o_command
);

    logic signed [dwpd_pkg::SUM_BITS-1:0] sum;
    logic signed [dwpd_pkg::SUM_BITS-1:0] shifted;
    logic signed [dwpd_pkg::CMD_BITS-1:0] cmd;
    logic signed [dwpd_pkg::CMD_BITS-1:0] hi_x;
    logic signed [dwpd_pkg::CMD_BITS-1:0] lo_x;
    logic signed [dwpd_pkg::CMD_BITS-1:0] clamped;

    assign sum     = dwpd_pkg::SUM_BITS'(i_prod.prod_p) + dwpd_pkg::SUM_BITS'(i_prod.prod_d);
    assign shifted = sum >>> dwpd_pkg::FRACTION_BITS;     // floor
    assign cmd     = shifted[dwpd_pkg::CMD_BITS-1:0];
    assign hi_x    = dwpd_pkg::CMD_BITS'(i_limit_high);
    assign lo_x    = dwpd_pkg::CMD_BITS'(i_limit_low);

    // low limit wins when the limits are crossed
    always_comb begin
        clamped = cmd;
        if (clamped > hi_x) begin
            clamped = hi_x;
        end
        if (clamped < lo_x) begin
            clamped = lo_x;
        end
    end

    assign o_command = clamped[dwpd_pkg::VALUE_BITS-1:0];

endmodule
`default_nettype wire

>>> rtl/dual_wheel_pd_velocity_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_wheel_pd_velocity_unit
// Two-wheel PD velocity controller with per-wheel command clamp.
// ----------------------------------------------------------------------------
// One item per cycle unless the receiver stalls; each item passes the product
// register, then the output register. The first half forms error, error change
// and gain products for both wheels and registers them; the second sums, shifts
// right by the fraction bits (floor) and clamps to the high then the low limit,
// into the output register. If both targets are zero both commands read zero,
// and the stored errors are still updated. Stored errors reset to zero. The user
// must write gains and limits through the plain write port only while no item is
// in flight; the block does not enforce it. Indexes 6 and 7 are ignored.
// ----------------------------------------------------------------------------
module dual_wheel_pd_velocity_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input items
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [15:0] target_left, [31:16] target_right,
    // [47:32] measured_left, [63:48] measured_right
    input  wire logic [4*dwpd_pkg::VALUE_BITS-1:0]  i_s_axis_tdata,
    // result items
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [15:0] command_left, [31:16] command_right
    output logic [2*dwpd_pkg::VALUE_BITS-1:0]       o_m_axis_tdata,
    // configuration
    input  wire logic                                i_cfg_wen,
    input  wire logic [dwpd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [dwpd_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int VB = dwpd_pkg::VALUE_BITS;

    dwpd_pkg::t_cfg cfg;

    logic signed [VB-1:0] target_l, target_r, meas_l, meas_r;
    logic signed [dwpd_pkg::ERR_BITS-1:0] err_l, err_r;
    dwpd_pkg::t_prod prod_l, prod_r;
    logic signed [VB-1:0] cmd_l, cmd_r;

    logic in_acc;      // input item taken this cycle
    logic out_free;    // output register can load this cycle

    // state and pipeline registers
    logic signed [dwpd_pkg::ERR_BITS-1:0] r_last_err_l, r_last_err_r;
    logic                                 r_s1_valid;
    logic                                 r_s1_zero;
    dwpd_pkg::t_prod                      r_s1_prod_l, r_s1_prod_r;
    logic                                 r_out_valid;
    logic [2*VB-1:0]                      r_out_data;
    logic [2*VB-1:0]                      n_out_data;

    dwpd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign target_l = i_s_axis_tdata[VB-1:0];
    assign target_r = i_s_axis_tdata[2*VB-1:VB];
    assign meas_l   = i_s_axis_tdata[3*VB-1:2*VB];
    assign meas_r   = i_s_axis_tdata[4*VB-1:3*VB];

    // handshake: output register is free when empty or being drained;
    // stage one takes an item when empty or moving into the output register
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || out_free;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // ---- first half: error and products ----
    dwpd_wheel_front u_front_l (
        .i_target     (target_l),
        .i_measured   (meas_l),
        .i_last_error (r_last_err_l),
        .i_prop_gain  (cfg.prop_gain),
        .i_deriv_gain (cfg.deriv_gain),
        .o_error      (err_l),
        .o_prod       (prod_l)
    );

    dwpd_wheel_front u_front_r (
        .i_target     (target_r),
        .i_measured   (meas_r),
        .i_last_error (r_last_err_r),
        .i_prop_gain  (cfg.prop_gain),
        .i_deriv_gain (cfg.deriv_gain),
        .o_error      (err_r),
        .o_prod       (prod_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err_l <= '0;
            r_last_err_r <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_last_err_l <= err_l;
                r_last_err_r <= err_r;
                r_s1_valid   <= 1'b1;
            end else if (out_free) begin
                r_s1_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_prod_l <= prod_l;
            r_s1_prod_r <= prod_r;
            r_s1_zero   <= (target_l == '0) && (target_r == '0);
        end
    end

    // ---- second half: sum, shift, clamp ----
    dwpd_wheel_back u_back_l (
        .i_prod       (r_s1_prod_l),
        .i_limit_high (cfg.left_limit_high),
        .i_limit_low  (cfg.left_limit_low),
        .o_command    (cmd_l)
    );

    dwpd_wheel_back u_back_r (
        .i_prod       (r_s1_prod_r),
        .i_limit_high (cfg.right_limit_high),
        .i_limit_low  (cfg.right_limit_low),
        .o_command    (cmd_r)
    );

    // both targets zero forces both commands to zero
    assign n_out_data = r_s1_zero ? '0 : {cmd_r, cmd_l};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---- assertions ----

    // stage one never overwritten while it holds an item that cannot move
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_acc && r_s1_valid && !out_free))
        else $error("stage one overwritten while stalled");

    // a zero-target item comes out as zero commands
    a_zero_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_free && r_s1_zero) |=> (o_m_axis_tdata == '0))
        else $error("zero targets gave nonzero command");

    // stored errors move only when an item is taken
    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> ($stable(r_last_err_l) && $stable(r_last_err_r)))
        else $error("stored error changed without an input item");

    // left command respects its limits when they are ordered
    a_left_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_free && !r_s1_zero && !i_cfg_wen
            && (cfg.left_limit_low <= cfg.left_limit_high))
        |=> (($signed(o_m_axis_tdata[VB-1:0]) <= cfg.left_limit_high)
            && ($signed(o_m_axis_tdata[VB-1:0]) >= cfg.left_limit_low)))
        else $error("left command outside its limits");

endmodule
`default_nettype wire

>>> bench/tb_dual_wheel_pd_velocity_unit.sv
// ----------------------------------------------------------------------------
// tb_dual_wheel_pd_velocity_unit
// Self-checking bench for the two-wheel PD velocity unit. A short stimulus
// table covers reset defaults, field extremes, forced-zero, crossed limits,
// floor rounding, wide products and unmapped register writes. Random phases
// then sweep gains and limits under bursty input and a stalling receiver.
// Each result is checked against a hand-derived value or an in-bench model.
// ----------------------------------------------------------------------------
module tb_dual_wheel_pd_velocity_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS    = dwpd_pkg::VALUE_BITS;
    localparam int FRACTION_BITS = dwpd_pkg::FRACTION_BITS;
    localparam int GAIN_BITS     = dwpd_pkg::GAIN_BITS;
    localparam int ERR_BITS      = dwpd_pkg::ERR_BITS;
    localparam int CFG_IDX_BITS  = dwpd_pkg::CFG_IDX_BITS;
    localparam int CFG_DATA_BITS = dwpd_pkg::CFG_DATA_BITS;

    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int CYCLE_LIMIT     = 250000;
    // output register plus product register, with a little margin
    localparam int DRAIN_CYCLES    = 4;

    // register indexes the block leaves unmapped
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    // input item, target_left in the lowest bits
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] measured_right;
        logic signed [VALUE_BITS-1:0] measured_left;
        logic signed [VALUE_BITS-1:0] target_right;
        logic signed [VALUE_BITS-1:0] target_left;
    } t_sample;

    // result item, command_left in the lowest bits
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] command_right;
        logic signed [VALUE_BITS-1:0] command_left;
    } t_cmd_pair;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;
    typedef enum logic [1:0] {RX_ALWAYS, RX_PATTERN, RX_RANDOM} t_rx_mode;

    typedef struct {
        t_row_kind                kind;
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
        t_sample                  sample;
        bit                       typed;    // want holds a hand-derived result
        t_cmd_pair                want;
    } t_stim_row;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_s_axis_tvalid;
    logic                     o_s_axis_tready;
    logic [4*VALUE_BITS-1:0]  i_s_axis_tdata;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready;
    logic [2*VALUE_BITS-1:0]  o_m_axis_tdata;
    logic                     i_cfg_wen;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    dual_wheel_pd_velocity_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    // shadow copy of the gains and limits, kept in step with every write
    logic        [GAIN_BITS-1:0]  kp_q;
    logic        [GAIN_BITS-1:0]  kd_q;
    logic signed [VALUE_BITS-1:0] left_hi_q;
    logic signed [VALUE_BITS-1:0] left_lo_q;
    logic signed [VALUE_BITS-1:0] right_hi_q;
    logic signed [VALUE_BITS-1:0] right_lo_q;
    // previous error per wheel, cleared at reset like the block's own
    logic signed [ERR_BITS-1:0]   left_err_q;
    logic signed [ERR_BITS-1:0]   right_err_q;

    t_cmd_pair cmd_expect_q[$];
    t_stim_row stim_table[$];

    int       fault_count     = 0;
    int       results_checked = 0;
    int       items_sent      = 0;
    int       reg_writes      = 0;
    int       cycle_count     = 0;
    int       burst_left      = 0;
    int       tx_max_gap      = 0;
    t_rx_mode rx_mode         = RX_ALWAYS;
    logic [7:0] rx_pattern    = 8'hFF;

    // ------------------------------------------------------------------
    // Controller model
    // ------------------------------------------------------------------
    // One wheel: exact products, floor shift, clamp high then low. The
    // crossed-limit case falls out of the order of the two compares.
    function automatic logic signed [VALUE_BITS-1:0] predict_wheel(
        input logic signed [VALUE_BITS-1:0] target,
        input logic signed [VALUE_BITS-1:0] measured,
        input logic signed [VALUE_BITS-1:0] hi,
        input logic signed [VALUE_BITS-1:0] lo,
        inout logic signed [ERR_BITS-1:0]   prev_err
    );
        longint err;
        longint delta;
        longint total;
        longint cmd;
        err      = longint'(target) - longint'(measured);
        delta    = err - longint'(prev_err);
        total    = longint'(kp_q) * err + longint'(kd_q) * delta;
        cmd      = total >>> FRACTION_BITS;
        prev_err = ERR_BITS'(err);
        if (cmd > longint'(hi)) cmd = longint'(hi);
        if (cmd < longint'(lo)) cmd = longint'(lo);
        return VALUE_BITS'(cmd);
    endfunction

    // Both wheels; errors are stored even when both targets are zero.
    function automatic t_cmd_pair predict_commands(input t_sample s);
        t_cmd_pair c;
        c.command_left  = predict_wheel(s.target_left, s.measured_left,
                                        left_hi_q, left_lo_q, left_err_q);
        c.command_right = predict_wheel(s.target_right, s.measured_right,
                                        right_hi_q, right_lo_q, right_err_q);
        if (s.target_left == 0 && s.target_right == 0) c = '0;
        return c;
    endfunction

    task automatic report_fault(input string msg);
        fault_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Stimulus table helpers
    // ------------------------------------------------------------------
    function automatic void add_cfg(input logic [CFG_IDX_BITS-1:0] idx, input int data);
        t_stim_row row;
        row.kind   = ROW_CFG;
        row.index  = idx;
        row.data   = CFG_DATA_BITS'(data);
        row.sample = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        stim_table.push_back(row);
    endfunction

    function automatic void add_item(input int tl, input int tr, input int ml, input int mr,
                                     input bit typed = 1'b0,
                                     input int wl = 0, input int wr = 0);
        t_stim_row row;
        row.kind                  = ROW_ITEM;
        row.index                 = '0;
        row.data                  = '0;
        row.sample.target_left    = VALUE_BITS'(tl);
        row.sample.target_right   = VALUE_BITS'(tr);
        row.sample.measured_left  = VALUE_BITS'(ml);
        row.sample.measured_right = VALUE_BITS'(mr);
        row.typed                 = typed;
        row.want.command_left     = VALUE_BITS'(wl);
        row.want.command_right    = VALUE_BITS'(wr);
        stim_table.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Random value sources
    // ------------------------------------------------------------------
    function automatic logic signed [VALUE_BITS-1:0] rand_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VALUE_BITS'($urandom);
            4, 5, 6:    return VALUE_BITS'($urandom_range(0, 4096) - 2048);
            7: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return '1;
                    default: return VALUE_BITS'(1);
                endcase
            end
            default:    return '0;
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_BITS'(256);
            3, 4:    return GAIN_BITS'($urandom_range(0, 1024));
            default: return GAIN_BITS'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Register write; the strobe drops after each write so it
    // never gets two updates in one step.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            dwpd_pkg::CFG_PROP_GAIN:        kp_q       = val[GAIN_BITS-1:0];
            dwpd_pkg::CFG_DERIV_GAIN:       kd_q       = val[GAIN_BITS-1:0];
            dwpd_pkg::CFG_LEFT_LIMIT_HIGH:  left_hi_q  = val[VALUE_BITS-1:0];
            dwpd_pkg::CFG_LEFT_LIMIT_LOW:   left_lo_q  = val[VALUE_BITS-1:0];
            dwpd_pkg::CFG_RIGHT_LIMIT_HIGH: right_hi_q = val[VALUE_BITS-1:0];
            dwpd_pkg::CFG_RIGHT_LIMIT_LOW:  right_lo_q = val[VALUE_BITS-1:0];
            default: ;  // unmapped index: no effect
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    // One limit pair: full range, reset value, ordered, crossed or equal.
    task automatic set_limits(input logic [CFG_IDX_BITS-1:0] hi_idx,
                              input logic [CFG_IDX_BITS-1:0] lo_idx);
        int a;
        int b;
        a = $urandom_range(0, 65535) - 32768;
        b = $urandom_range(0, 65535) - 32768;
        case ($urandom_range(0, 4))
            0: begin
                a = 32767;
                b = -32768;
            end
            1: begin
                a = 25600;
                b = 0;
            end
            2: if (a < b) {a, b} = {b, a};
            3: if (a > b) {a, b} = {b, a};   // low above high
            default: b = a;
        endcase
        write_reg(hi_idx, CFG_DATA_BITS'(a));
        write_reg(lo_idx, CFG_DATA_BITS'(b));
    endtask

    // Quiet the input side and wait until every result is back.
    task automatic wait_drained();
        if (i_s_axis_tvalid) i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (cmd_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // Send one item inside the current burst; a new burst may open with a
    // gap. On accept the model runs, and the hand-derived result replaces
    // its answer where the row carries one.
    task automatic send_item(input t_sample s, input bit typed,
                             input t_cmd_pair want);
        int gap;
        t_cmd_pair predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
            if (gap != 0) begin
                if (i_s_axis_tvalid) i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predicted = predict_commands(s);
        cmd_expect_q.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: always ready, a rotating stall pattern, or random stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        case (rx_mode)
            RX_ALWAYS:  i_m_axis_tready <= 1'b1;
            RX_PATTERN: i_m_axis_tready <= rx_pattern[cycle_count[2:0]];
            default:    i_m_axis_tready <= ($urandom_range(0, 9) >= 4);
        endcase
    end

    // ------------------------------------------------------------------
    // Result checker: in-order compare against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_cmd_pair got;
        t_cmd_pair want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (cmd_expect_q.size() == 0) begin
                report_fault($sformatf("result %0d/%0d with nothing pending",
                                       got.command_left, got.command_right));
            end else begin
                want = cmd_expect_q.pop_front();
                results_checked++;
                if (got.command_left !== want.command_left)
                    report_fault($sformatf("command_left got %0d want %0d",
                                           got.command_left, want.command_left));
                if (got.command_right !== want.command_right)
                    report_fault($sformatf("command_right got %0d want %0d",
                                           got.command_right, want.command_right));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, cmd_expect_q.size());
            $display("tb_dual_wheel_pd_velocity_unit failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_sample s;
        int phase;
        int k;

        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_wen       <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;

        kp_q        = dwpd_pkg::PROP_GAIN_RST;
        kd_q        = dwpd_pkg::DERIV_GAIN_RST;
        left_hi_q   = dwpd_pkg::LIMIT_HIGH_RST;
        left_lo_q   = dwpd_pkg::LIMIT_LOW_RST;
        right_hi_q  = dwpd_pkg::LIMIT_HIGH_RST;
        right_lo_q  = dwpd_pkg::LIMIT_LOW_RST;
        left_err_q  = '0;
        right_err_q = '0;

        // -- directed table --------------------------------------------
        // reset defaults: Kp 1.0, Kd 0, limits [0, 25600]
        add_item(0, 0, 0, 0, 1'b1, 0, 0);
        add_item(256, 512, 0, 0, 1'b1, 256, 512);
        add_item(0, 0, 1000, -1000, 1'b1, 0, 0);              // both targets zero
        add_item(32767, 32767, -32768, -32768, 1'b1, 25600, 25600);
        add_item(-32768, -32768, 32767, 32767, 1'b1, 0, 0);
        add_item(0, 100, -100, 0, 1'b1, 100, 100);            // one target zero only
        // widest gains, full-range limits: exact wide products
        add_cfg(dwpd_pkg::CFG_PROP_GAIN, 65535);
        add_cfg(dwpd_pkg::CFG_DERIV_GAIN, 65535);
        add_cfg(dwpd_pkg::CFG_LEFT_LIMIT_HIGH, 32767);
        add_cfg(dwpd_pkg::CFG_LEFT_LIMIT_LOW, -32768);
        add_cfg(dwpd_pkg::CFG_RIGHT_LIMIT_HIGH, 32767);
        add_cfg(dwpd_pkg::CFG_RIGHT_LIMIT_LOW, -32768);
        add_item(32767, -32768, -32768, 32767);
        add_item(-32768, 32767, 32767, -32768);
        add_item(1, -1, 0, 0);
        add_item(-1, 1, 0, 0);
        add_item(0, 0, 5, -5, 1'b1, 0, 0);                    // forced zero, errors kept
        add_item(100, 100, 0, 0);
        // zero gains with crossed limits: command sits at the low limit
        add_cfg(dwpd_pkg::CFG_PROP_GAIN, 0);
        add_cfg(dwpd_pkg::CFG_DERIV_GAIN, 0);
        add_cfg(dwpd_pkg::CFG_LEFT_LIMIT_HIGH, -1000);
        add_cfg(dwpd_pkg::CFG_LEFT_LIMIT_LOW, 1000);
        add_cfg(dwpd_pkg::CFG_RIGHT_LIMIT_HIGH, -32768);
        add_cfg(dwpd_pkg::CFG_RIGHT_LIMIT_LOW, 32767);
        add_item(300, -300, 0, 0, 1'b1, 1000, 32767);
        // unmapped indexes must leave everything as it was
        add_cfg(CFG_SPARE_LO, 0);
        add_cfg(CFG_SPARE_HI, 65535);
        add_item(300, -300, 7, 7, 1'b1, 1000, 32767);
        // smallest gain: the shift floors toward minus infinity
        add_cfg(dwpd_pkg::CFG_PROP_GAIN, 1);
        add_cfg(dwpd_pkg::CFG_LEFT_LIMIT_HIGH, 32767);
        add_cfg(dwpd_pkg::CFG_LEFT_LIMIT_LOW, -32768);
        add_cfg(dwpd_pkg::CFG_RIGHT_LIMIT_HIGH, 32767);
        add_cfg(dwpd_pkg::CFG_RIGHT_LIMIT_LOW, -32768);
        add_item(-1, 1, 0, 0, 1'b1, -1, 0);
        add_item(-256, 255, 0, 0);
        // derivative term alone
        add_cfg(dwpd_pkg::CFG_PROP_GAIN, 0);
        add_cfg(dwpd_pkg::CFG_DERIV_GAIN, 256);
        add_item(500, 500, 0, 0);
        add_item(500, 500, 0, 0);
        add_item(-500, 200, 0, 0);
        add_item(12000, -12000, -9000, 9000);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // light idling on both sides through the table
        tx_max_gap = 2;
        rx_pattern = 8'b1011_0111;
        rx_mode    = RX_PATTERN;
        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(stim_table[i].index, stim_table[i].data);
            end else begin
                send_item(stim_table[i].sample, stim_table[i].typed, stim_table[i].want);
            end
        end

        // -- random phases ---------------------------------------------
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            write_reg(dwpd_pkg::CFG_PROP_GAIN, CFG_DATA_BITS'(rand_gain()));
            write_reg(dwpd_pkg::CFG_DERIV_GAIN, CFG_DATA_BITS'(rand_gain()));
            set_limits(dwpd_pkg::CFG_LEFT_LIMIT_HIGH, dwpd_pkg::CFG_LEFT_LIMIT_LOW);
            set_limits(dwpd_pkg::CFG_RIGHT_LIMIT_HIGH, dwpd_pkg::CFG_RIGHT_LIMIT_LOW);
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                          CFG_DATA_BITS'($urandom));

            // phase 0 runs at full rate on both sides
            tx_max_gap = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
            rx_pattern = 8'($urandom) | 8'h01;
            case (phase % 4)
                0:       rx_mode = RX_ALWAYS;
                2:       rx_mode = RX_RANDOM;
                default: rx_mode = RX_PATTERN;
            endcase

            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                s.target_left  = rand_value();
                s.target_right = rand_value();
                // mostly a wheel tracking its target, sometimes anything
                if ($urandom_range(0, 2) != 0)
                    s.measured_left = s.target_left + VALUE_BITS'($urandom_range(0, 64) - 32);
                else
                    s.measured_left = rand_value();
                if ($urandom_range(0, 2) != 0)
                    s.measured_right = s.target_right + VALUE_BITS'($urandom_range(0, 64) - 32);
                else
                    s.measured_right = rand_value();
                if ($urandom_range(0, 19) == 0) begin
                    s.target_left  = '0;
                    s.target_right = '0;
                end
                send_item(s, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items through %0d register writes (%0d random setups), %0d results",
                 items_sent, reg_writes, RANDOM_PHASES, results_checked);
        $display("%0d mismatches", fault_count);
        if (fault_count == 0) begin
            $display("tb_dual_wheel_pd_velocity_unit passed");
        end else begin
            $display("tb_dual_wheel_pd_velocity_unit failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/dwpd_pkg.sv
rtl/dwpd_cfg_regs.sv
rtl/dwpd_wheel_front.sv
rtl/dwpd_wheel_back.sv
rtl/dual_wheel_pd_velocity_unit.sv
bench/tb_dual_wheel_pd_velocity_unit.sv
